// ----- sv/fee_band_space_allocator_unit_assert.svh -----
// Assertion macros for the fee band space allocator checker.
// No dependencies; include by bare file name.
`ifndef FEE_BAND_SPACE_ALLOCATOR_UNIT_ASSERT_SVH
`define FEE_BAND_SPACE_ALLOCATOR_UNIT_ASSERT_SVH

// Concurrent assertion on an explicit clock, disabled while reset is low.
`define FBSA_ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define FBSA_ASSERT(lbl, prop, msg) \
  `FBSA_ASSERT_CLKD(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/fbsa_pkg.sv -----
// Shared types and constants of the fee band space allocator.
// No dependencies.
`timescale 1ns / 1ps

package fbsa_pkg;

  localparam int unsigned NumBands = 4;
  localparam int unsigned BandW    = 2;
  localparam int unsigned RoomW    = 24;
  localparam int unsigned FeeW     = 42;
  localparam int unsigned FloorW   = 32;
  localparam int unsigned FeeShift = 10;  // floors compare after x1024
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [BandW-1:0] BandTop       = BandW'(NumBands - 1);
  localparam logic [RoomW-1:0] BlockSpaceRst = 24'd1048576;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BANDS_EN    = 3'd0,
    REG_BLOCK_SPACE = 3'd1,
    REG_FLOOR1      = 3'd2,
    REG_FLOOR2      = 3'd3,
    REG_FLOOR3      = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIT,
    ST_EXCESS,
    ST_SPILL,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ALU_FEE_CMP,  // fee - floor*1024
    ALU_FIT,      // room - size
    ALU_EXCESS,   // size - room
    ALU_SPILL     // room - excess
  } alu_op_e;

  typedef struct packed {
    logic             first_of_block;
    logic [FeeW-1:0]  item_fee_ratio;
    logic [RoomW-1:0] item_size;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic [BandW-1:0] band_index;
  } out_item_t;

  typedef struct packed {
    logic             borrow;
    logic [RoomW-1:0] diff;
  } alu_res_t;

endpackage

// ----- sv/fbsa_alu.sv -----
// Shared subtract/compare unit of the fee band space allocator.
// Depends on fbsa_pkg.
`timescale 1ns / 1ps

module fbsa_alu
  import fbsa_pkg::*;
(
  input  alu_op_e           op_i,
  input  logic [FeeW-1:0]   fee_i,
  input  logic [FloorW-1:0] floor_i,
  input  logic [RoomW-1:0]  room_i,
  input  logic [RoomW-1:0]  size_i,
  input  logic [RoomW-1:0]  excess_i,
  output alu_res_t          res_o
);

  logic [FeeW-1:0] opa, opb;
  logic [FeeW:0]   sub;

  always_comb begin
    unique case (op_i)
      ALU_FEE_CMP: begin
        opa = fee_i;
        opb = {floor_i, FeeShift'(0)};
      end
      ALU_FIT: begin
        opa = FeeW'(room_i);
        opb = FeeW'(size_i);
      end
      ALU_EXCESS: begin
        opa = FeeW'(size_i);
        opb = FeeW'(room_i);
      end
      ALU_SPILL: begin
        opa = FeeW'(room_i);
        opb = FeeW'(excess_i);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign sub          = {1'b0, opa} - {1'b0, opb};
  assign res_o.borrow = sub[FeeW];
  assign res_o.diff   = sub[RoomW-1:0];

endmodule

// ----- sv/fee_band_space_allocator_unit.sv -----
// Top level of the fee band space allocator: config registers, band rooms,
// sequencer and output register. Depends on fbsa_pkg and fbsa_alu.
`timescale 1ns / 1ps

// Fee band space allocator. Candidate items of one block arrive in order;
// an item with first_of_block set splits block_space into four bands
// (band i gets ((i+1)*S)/4 - (i*S)/4 units) and moves the band pointer to
// the top band. The pointer then steps down, one band per cycle, while the
// band is empty or the fee ratio is below that band's floor x1024; the item
// is placed there and any excess spills into the band below (clamped at
// zero). An item that does not fit in band 0 is rejected. With bands
// disabled each item is accepted at band 0 and the rooms are untouched, but
// first_of_block still re-splits them. One transaction at a time: an item
// goes from accept through scan (one band compare per cycle through the
// shared subtractor), fit, and excess and spill when it spills, to done,
// which loads the output register; with bands disabled it goes from accept
// straight to done. in_stall_o is high from accept until the result is
// loaded. The output register lets the next transaction start while a
// result waits downstream; the load waits only if that register is occupied.
// Configuration is written through a plain write port and should only be
// changed while the block is idle. A new block_space takes effect at the
// next first_of_block.

module fee_band_space_allocator_unit
  import fbsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // candidate items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  // band room of one band after a block restart
  function automatic logic [RoomW-1:0] band_init(logic [RoomW-1:0] space,
                                                 logic [BandW-1:0] band);
    logic [1:0] rem;
    logic       extra;
    rem = space[1:0];
    unique case (band)
      2'd0:    extra = 1'b0;
      2'd1:    extra = rem[1];
      2'd2:    extra = (rem == 2'd3);
      default: extra = (rem != 2'd0);
    endcase
    return RoomW'(space[RoomW-1:2]) + RoomW'(extra);
  endfunction

  // ---------------- configuration registers
  logic              bands_en_q;
  logic [RoomW-1:0]  block_space_q;
  logic [FloorW-1:0] floor1_q, floor2_q, floor3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bands_en_q    <= 1'b1;
      block_space_q <= BlockSpaceRst;
      floor1_q      <= '0;
      floor2_q      <= '0;
      floor3_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BANDS_EN:    bands_en_q    <= cfg_wdata_i[0];
        REG_BLOCK_SPACE: block_space_q <= cfg_wdata_i[RoomW-1:0];
        REG_FLOOR1:      floor1_q      <= cfg_wdata_i[FloorW-1:0];
        REG_FLOOR2:      floor2_q      <= cfg_wdata_i[FloorW-1:0];
        REG_FLOOR3:      floor3_q      <= cfg_wdata_i[FloorW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- sequencer state and datapath registers
  state_e            state_q, state_d;
  logic [BandW-1:0]  band_q, band_d;       // current band pointer
  logic [BandW-1:0]  res_band_q, res_band_d;
  logic              acc_q, acc_d;
  logic [RoomW-1:0]  excess_q, excess_d;
  logic [FeeW-1:0]   fee_q;
  logic [RoomW-1:0]  size_q;
  logic [RoomW-1:0]  room_q [NumBands];

  logic              in_acc;
  logic              restart;
  logic              out_free;
  logic              out_load;
  logic              room_we;
  logic [BandW-1:0]  room_wa;
  logic [RoomW-1:0]  room_wd;
  logic [BandW-1:0]  room_ra;
  logic [RoomW-1:0]  room_rd;
  logic [FloorW-1:0] floor_sel;
  alu_op_e           alu_op;
  alu_res_t          alu_res;

  logic              out_valid_q;
  out_item_t         out_data_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign restart    = in_acc && in_data_i.first_of_block;
  assign out_free   = !out_valid_q || !out_stall_i;

  // single room read port: the band below during a spill, else the current
  assign room_ra = (state_q == ST_SPILL) ? band_q - BandW'(1) : band_q;
  assign room_rd = room_q[room_ra];

  always_comb begin
    unique case (band_q)
      2'd1:    floor_sel = floor1_q;
      2'd2:    floor_sel = floor2_q;
      2'd3:    floor_sel = floor3_q;
      default: floor_sel = '0;  // band 0 has no floor
    endcase
  end

  fbsa_alu u_alu (
    .op_i     (alu_op),
    .fee_i    (fee_q),
    .floor_i  (floor_sel),
    .room_i   (room_rd),
    .size_i   (size_q),
    .excess_i (excess_q),
    .res_o    (alu_res)
  );

  always_comb begin
    state_d    = state_q;
    band_d     = band_q;
    res_band_d = res_band_q;
    acc_d      = acc_q;
    excess_d   = excess_q;
    room_we    = 1'b0;
    room_wa    = band_q;
    room_wd    = alu_res.diff;
    alu_op     = ALU_FEE_CMP;
    out_load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.first_of_block) begin
            band_d = BandTop;
          end
          if (!bands_en_q) begin
            acc_d      = 1'b1;
            res_band_d = '0;
            state_d    = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // step down on an empty band or a fee under the band floor
        alu_op = ALU_FEE_CMP;
        if (band_q != '0 && (room_rd == '0 || alu_res.borrow)) begin
          band_d = band_q - BandW'(1);
        end else begin
          state_d = ST_FIT;
        end
      end
      ST_FIT: begin
        alu_op = ALU_FIT;
        if (!alu_res.borrow) begin
          room_we    = 1'b1;
          acc_d      = 1'b1;
          res_band_d = band_q;
          state_d    = ST_DONE;
        end else if (band_q == '0) begin
          acc_d      = 1'b0;  // no room in the lowest band
          res_band_d = '0;
          state_d    = ST_DONE;
        end else begin
          state_d = ST_EXCESS;
        end
      end
      ST_EXCESS: begin
        alu_op   = ALU_EXCESS;
        excess_d = alu_res.diff;
        room_we  = 1'b1;
        room_wd  = '0;
        state_d  = ST_SPILL;
      end
      ST_SPILL: begin
        alu_op     = ALU_SPILL;
        room_we    = 1'b1;
        room_wa    = band_q - BandW'(1);
        room_wd    = alu_res.borrow ? '0 : alu_res.diff;
        acc_d      = 1'b1;
        res_band_d = band_q;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      band_q      <= BandTop;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBands; i++) begin
        room_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      band_q  <= band_d;
      if (restart) begin
        for (int i = 0; i < NumBands; i++) begin
          room_q[i] <= band_init(block_space_q, BandW'(i));
        end
      end else if (room_we) begin
        room_q[room_wa] <= room_wd;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    res_band_q <= res_band_d;
    acc_q      <= acc_d;
    excess_q   <= excess_d;
    if (in_acc) begin
      fee_q  <= in_data_i.item_fee_ratio;
      size_q <= in_data_i.item_size;
    end
    if (out_load) begin
      out_data_q.accepted   <= acc_q;
      out_data_q.band_index <= res_band_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/fbsa_checker.sv -----
// Port-level checker for the fee band space allocator, bound to the top.
// Depends on fbsa_pkg and fee_band_space_allocator_unit_assert.svh.
`timescale 1ns / 1ps
`include "fee_band_space_allocator_unit_assert.svh"

module fbsa_checker
  import fbsa_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_item_t           out_data_o
);

  // a rejected transaction only ever comes from band 0
  `FBSA_ASSERT(a_reject_band0, (out_valid_o && !out_data_o.accepted) |-> (out_data_o.band_index == '0), "rejected item not in band 0")

  // one transaction at a time: input is held off right after an accept
  `FBSA_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "input not stalled after accept")

  // result valid holds while stalled
  `FBSA_ASSERT(a_out_valid_hold, (out_valid_o && out_stall_i) |=> out_valid_o, "result dropped under stall")

  // result payload holds while stalled
  `FBSA_ASSERT(a_out_data_hold, (out_valid_o && out_stall_i) |=> $stable(out_data_o), "result changed under stall")

endmodule

bind fee_band_space_allocator_unit fbsa_checker u_fbsa_checker (.*);

// ----- verif/tb_fee_band_space_allocator_unit.sv -----
// Self-checking testbench for fee_band_space_allocator_unit: directed table,
// then randomized block runs with random idling on both channels.
// Depends on fbsa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_fee_band_space_allocator_unit;
  import fbsa_pkg::*;

  // Run shape
  localparam int unsigned NumPhases  = 12;   // register settings in the random part
  localparam int unsigned PhaseItems = 152;  // candidate items per setting
  localparam int unsigned HoldPhase  = 3;    // phase that opens with a long output hold
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 20;   // > worst item latency

  localparam logic [FeeW-1:0]     FeeMax    = {FeeW{1'b1}};
  localparam logic [RoomW-1:0]    SizeMax   = {RoomW{1'b1}};
  localparam logic [FloorW-1:0]   FloorMax  = {FloorW{1'b1}};
  localparam logic [CfgIdxW-1:0]  RegUnused = 3'd7;  // not decoded, write must be dropped

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  wdata;
    in_item_t             item;
    bit                   typed;   // answer column filled in by hand
    out_item_t            answer;
  } plan_row_t;

  typedef struct {
    bit        typed;
    out_item_t answer;
  } hint_t;

  // DUT ports
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;

  fee_band_space_allocator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fallback end of run, well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Allocation predictor: own copy of the registers and the band state.
  // ---------------------------------------------------------------------------
  logic                 cfg_bands_en  = 1'b1;
  logic [RoomW-1:0]     cfg_space     = BlockSpaceRst;
  logic [FloorW-1:0]    cfg_floor [NumBands] = '{default: '0};  // entry 0 unused
  logic [RoomW-1:0]     room      [NumBands] = '{default: '0};
  logic [BandW-1:0]     cur_band      = BandTop;

  out_item_t   pending_results [$];  // predicted results, oldest first
  hint_t       answer_hints [$];     // hand-typed answers, one per item sent
  plan_row_t   plan [$];

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned writes_done  = 0;
  int unsigned err_cnt      = 0;
  bit          hold_req     = 1'b0;
  bit          calm         = 1'b0;  // no idling on either side

  function automatic out_item_t allocate_item(input in_item_t it);
    logic [63:0]      hi, lo, floor_scaled;
    logic [RoomW-1:0] excess;
    logic [BandW-1:0] b;
    out_item_t        r;
    // first_of_block re-splits the space, even with bands disabled
    if (it.first_of_block) begin
      for (int i = 0; i < NumBands; i++) begin
        hi = (64'(i + 1) * 64'(cfg_space)) / NumBands;
        lo = (64'(i) * 64'(cfg_space)) / NumBands;
        room[i] = RoomW'(hi - lo);
      end
      cur_band = BandTop;
    end
    r.accepted   = 1'b1;
    r.band_index = '0;
    if (!cfg_bands_en) return r;

    // pointer only walks down; band 0 has no floor
    b = cur_band;
    while (b != 0) begin
      floor_scaled = 64'(cfg_floor[b]) << FeeShift;
      if (room[b] != 0 && 64'(it.item_fee_ratio) >= floor_scaled) break;
      b = b - 1'b1;
    end
    cur_band = b;

    if (it.item_size > room[b]) begin
      if (b != 0) begin
        excess      = it.item_size - room[b];
        room[b - 1] = (excess > room[b - 1]) ? '0 : room[b - 1] - excess;
        room[b]     = '0;
      end else begin
        r.accepted = 1'b0;
      end
    end else begin
      room[b] = room[b] - it.item_size;
    end
    r.band_index = b;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Watcher: register writes, accepted candidates, accepted results.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hint_t     hint;
    out_item_t predicted, want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BANDS_EN:    cfg_bands_en = cfg_wdata_i[0];
          REG_BLOCK_SPACE: cfg_space    = cfg_wdata_i[RoomW-1:0];
          REG_FLOOR1:      cfg_floor[1] = cfg_wdata_i;
          REG_FLOOR2:      cfg_floor[2] = cfg_wdata_i;
          REG_FLOOR3:      cfg_floor[3] = cfg_wdata_i;
          default: ;  // unmapped index: no effect
        endcase
      end
      // candidate transaction: run the predictor, keep its answer or the typed one
      if (in_valid_i && !in_stall_o) begin
        hint = '{typed: 1'b0, answer: '0};
        if (answer_hints.size() != 0) hint = answer_hints.pop_front();
        predicted = allocate_item(in_data_i);
        if (hint.typed) predicted = hint.answer;
        pending_results = {pending_results, predicted};
      end
      // result transaction: compare with the oldest expectation
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (!out_data_o.accepted) rejects_seen++;
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result accepted=%0b band=%0d", $time,
                   out_data_o.accepted, out_data_o.band_index);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.accepted !== want.accepted) begin
            err_cnt++;
            $display("%0t: accepted mismatch, expected %0b got %0b", $time,
                     want.accepted, out_data_o.accepted);
          end
          if (out_data_o.band_index !== want.band_index) begin
            err_cnt++;
            $display("%0t: band_index mismatch, expected %0d got %0d", $time,
                     want.band_index, out_data_o.band_index);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: short random stalls, one long hold on request, none when calm.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Candidate side
  // ---------------------------------------------------------------------------
  function automatic void add_write(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_WRITE, idx: idx, wdata: data, item: '0, typed: 1'b0, answer: '0};
    plan = {plan, row};
  endfunction

  function automatic void add_item(input logic first, input logic [FeeW-1:0] fee,
                                   input logic [RoomW-1:0] size, input bit typed,
                                   input logic acc, input logic [BandW-1:0] band);
    plan_row_t row;
    row.kind   = ROW_ITEM;
    row.idx    = '0;
    row.wdata  = '0;
    row.item   = '{first_of_block: first, item_fee_ratio: fee, item_size: size};
    row.typed  = typed;
    row.answer = '{accepted: acc, band_index: band};
    plan = {plan, row};
  endfunction

  // Holds valid until the transaction goes through; optional idle burst first.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t ans);
    hint_t hint;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    hint = '{typed: typed, answer: ans};
    answer_hints = {answer_hints, hint};
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Block idle: every transaction sent has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    writes_done++;
  endtask

  initial begin
    in_item_t         it;
    logic             en;
    logic [RoomW-1:0] space;
    logic [FloorW-1:0] fl [NumBands];
    logic [63:0]      base;
    int unsigned      j;

    // Directed table. Typed answers where they are obvious, predictor elsewhere.
    // Reset state: all rooms empty, pointer at top, floors zero.
    add_item(1'b0, '0,     '0,      1, 1'b1, 2'd0);  // no block yet, size 0 fits
    add_item(1'b0, '0,     24'd1,   1, 1'b0, 2'd0);  // no block yet, rejected
    add_item(1'b1, FeeMax, '0,      1, 1'b1, 2'd3);  // restart, top band
    add_item(1'b0, FeeMax, SizeMax, 1, 1'b1, 2'd3);  // spill empties band 2 (clamp)
    add_item(1'b0, FeeMax, 24'd1,   1, 1'b1, 2'd1);  // skip two empty bands
    add_write(REG_FLOOR3, FloorMax);
    add_write(REG_FLOOR2, 32'd100);
    add_write(REG_FLOOR1, 32'd1);
    add_item(1'b1, FeeMax,              '0, 1, 1'b1, 2'd3);  // max fee clears max floor
    add_item(1'b1, FeeMax - 42'd1024,   '0, 1, 1'b1, 2'd2);  // one below floor3 x1024
    add_item(1'b1, 42'd102399,          '0, 1, 1'b1, 2'd1);  // one below floor2 x1024
    add_item(1'b1, 42'd1023, 24'd262144,   1, 1'b1, 2'd0);   // exact fit in band 0
    add_item(1'b0, FeeMax,   24'd1,        1, 1'b0, 2'd0);   // pointer never climbs
    add_item(1'b1, 42'd102400, 24'd262145, 0, 1'b0, 2'd0);   // spill of one unit
    add_item(1'b0, 42'd102400, '0,         0, 1'b0, 2'd0);
    add_write(REG_BANDS_EN, 32'd0);
    add_item(1'b0, '0,     SizeMax, 1, 1'b1, 2'd0);  // disabled: always accepted
    add_item(1'b1, FeeMax, 24'd5,   1, 1'b1, 2'd0);  // disabled, restart still taken
    add_write(REG_BANDS_EN, 32'd1);
    add_item(1'b0, FeeMax, 24'd5,   0, 1'b0, 2'd0);
    add_write(REG_BLOCK_SPACE, 32'd0);               // only seen at next restart
    add_item(1'b0, FeeMax, 24'd1,   0, 1'b0, 2'd0);
    add_item(1'b1, FeeMax, '0,      1, 1'b1, 2'd0);  // zero space: size 0 still fits
    add_item(1'b0, FeeMax, 24'd1,   1, 1'b0, 2'd0);
    add_write(REG_BLOCK_SPACE, 32'd1);               // all of it lands in band 3
    add_item(1'b1, FeeMax, 24'd1,   0, 1'b0, 2'd0);
    add_item(1'b0, FeeMax, 24'd1,   1, 1'b0, 2'd0);
    add_write(REG_BLOCK_SPACE, 32'(SizeMax));
    add_item(1'b1, FeeMax, SizeMax, 0, 1'b0, 2'd0);
    add_write(RegUnused, 32'hFFFF_FFFF);             // must be dropped
    add_item(1'b0, '0,     '0,      0, 1'b0, 2'd0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        settle();
        program_reg(plan[r].idx, plan[r].wdata);
      end else begin
        send_item(plan[r].item, plan[r].typed, plan[r].answer);
      end
    end

    // Random part: one register setting per phase, runs of blocks inside it.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      if (p == NumPhases - 1) calm = 1'b1;
      fl[0] = '0;
      case (p)
        0: begin  // widest space, highest floors
          en = 1'b1; space = SizeMax; fl[1] = FloorMax; fl[2] = FloorMax; fl[3] = FloorMax;
        end
        1: begin  // smallest nonzero space, no floors
          en = 1'b1; space = 24'd1; fl[1] = '0; fl[2] = '0; fl[3] = '0;
        end
        2: begin
          en = 1'b0; space = RoomW'($urandom_range(1, 4096));
          fl[1] = $urandom; fl[2] = $urandom; fl[3] = $urandom;
        end
        default: begin
          en = ($urandom_range(0, 7) != 0);
          case ($urandom_range(0, 9))
            0:       space = '0;
            1, 2:    space = RoomW'($urandom_range(1, 64));
            3, 4, 5: space = RoomW'($urandom_range(65, 8192));
            6, 7, 8: space = RoomW'($urandom_range(8193, 1 << 20));
            default: space = RoomW'($urandom_range(1 << 20, 32'(SizeMax)));
          endcase
          if ($urandom_range(0, 4) == 0) begin
            fl[1] = $urandom; fl[2] = $urandom; fl[3] = $urandom;
          end else begin
            fl[1] = $urandom_range(0, 2000);
            fl[2] = fl[1] + $urandom_range(0, 4000);
            fl[3] = fl[2] + $urandom_range(0, 8000);
          end
        end
      endcase
      program_reg(REG_BANDS_EN,    32'(en));
      program_reg(REG_BLOCK_SPACE, 32'(space));
      program_reg(REG_FLOOR1,      fl[1]);
      program_reg(REG_FLOOR2,      fl[2]);
      program_reg(REG_FLOOR3,      fl[3]);
      if (p == HoldPhase) hold_req = 1'b1;  // output held while input keeps coming

      for (int k = 0; k < PhaseItems; k++) begin
        it.first_of_block = (k == 0) ? ($urandom_range(0, 3) != 0)
                                     : ($urandom_range(0, 11) == 0);
        // fees mostly straddle one of the band floors
        case ($urandom_range(0, 7))
          0:       it.item_fee_ratio = FeeW'({$urandom, $urandom});
          1:       it.item_fee_ratio = $urandom_range(0, 1) ? FeeMax : '0;
          default: begin
            j    = $urandom_range(1, 3);
            base = 64'(fl[j]) << FeeShift;
            if ($urandom_range(0, 1)) base = base + $urandom_range(0, 1023);
            else                      base = base - $urandom_range(0, 1024);
            it.item_fee_ratio = FeeW'(base);
          end
        endcase
        // sizes mostly a fraction of a band, sometimes anything
        case ($urandom_range(0, 9))
          0:       it.item_size = RoomW'($urandom);
          1:       it.item_size = '0;
          2:       it.item_size = space >> 2;
          default: it.item_size = RoomW'($urandom_range(0, 32'(space) / 6 + 1));
        endcase
        send_item(it, 1'b0, '0);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);  // catch any stray result

    $display("Ran %0d candidate items (%0d rejected, %0d results) across %0d register writes",
             items_sent, rejects_seen, results_seen, writes_done);
    $display("Covered disabled bands, zero/min/max block space and floors, spills and holds");
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_cnt, pending_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/fbsa_pkg.sv
sv/fbsa_alu.sv
sv/fee_band_space_allocator_unit.sv
sv/fbsa_checker.sv
verif/tb_fee_band_space_allocator_unit.sv
